>>> src/rgb_box_blur_3x3_core_macros.svh
// Assertion helpers shared by the blur core. Each expects clk_i and rst_ni in scope.
`ifndef RGB_BOX_BLUR_3X3_CORE_MACROS_SVH
`define RGB_BOX_BLUR_3X3_CORE_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define RBB_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define RBB_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/rbb_pkg.sv
package rbb_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned MIN_DIM    = 3;

  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned IMG_W_W    = 12;
  localparam int unsigned IMG_H_W    = 13;
  // row index runs to height + 1 while draining
  localparam int unsigned ROW_W      = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 3 * CH_W;
  localparam int unsigned LINE_W     = 2 * PIX_W;
  localparam int unsigned CSUM_W     = CH_W + 2;
  localparam int unsigned TOT_W      = CH_W + 4;

  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = IMG_W_W'(640);
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = IMG_H_W'(480);

  // floor(t / 9) == (t * 3641) >> 15 for every t below 4096
  localparam int unsigned RECIP_9     = 3641;
  localparam int unsigned RECIP_W     = 12;
  localparam int unsigned RECIP_SHIFT = 15;

  localparam int unsigned OUT_DEPTH   = 8;
  localparam int unsigned OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CSUM_W-1:0] red;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] blue;
  } csum_t;

  typedef struct packed {
    logic  emit;
    logic  interior;
    logic  frame_end;
    rgb_t  center;
    csum_t older;
    csum_t middle;
    csum_t newest;
  } avg_req_t;

  typedef struct packed {
    logic frame_end;
    rgb_t pix;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } avg_rsp_t;

  function automatic csum_t col_sum(rgb_t a, rgb_t b, rgb_t c);
    csum_t s;
    s.red   = CSUM_W'(a.red)   + CSUM_W'(b.red)   + CSUM_W'(c.red);
    s.green = CSUM_W'(a.green) + CSUM_W'(b.green) + CSUM_W'(c.green);
    s.blue  = CSUM_W'(a.blue)  + CSUM_W'(b.blue)  + CSUM_W'(c.blue);
    return s;
  endfunction

endpackage

>>> src/rbb_in_if.sv
interface rbb_in_if;
  logic                    valid;
  logic                    ready;
  logic [rbb_pkg::CH_W-1:0] red_in;
  logic [rbb_pkg::CH_W-1:0] green_in;
  logic [rbb_pkg::CH_W-1:0] blue_in;
  logic                    flush;

  modport source (output valid, red_in, green_in, blue_in, flush, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, flush, output ready);
endinterface

>>> src/rbb_out_if.sv
interface rbb_out_if;
  logic                    valid;
  logic                    ready;
  logic [rbb_pkg::CH_W-1:0] red_out;
  logic [rbb_pkg::CH_W-1:0] green_out;
  logic [rbb_pkg::CH_W-1:0] blue_out;
  logic                    frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

>>> src/rbb_ram.sv
module rbb_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // a read of the entry being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/rbb_avg.sv
module rbb_avg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rbb_pkg::avg_req_t req_i,
  output rbb_pkg::avg_rsp_t rsp_o
);

  typedef struct packed {
    logic [rbb_pkg::TOT_W-1:0] red;
    logic [rbb_pkg::TOT_W-1:0] green;
    logic [rbb_pkg::TOT_W-1:0] blue;
  } tot_t;

  function automatic logic [rbb_pkg::CH_W-1:0] div9(logic [rbb_pkg::TOT_W-1:0] t);
    logic [rbb_pkg::TOT_W+rbb_pkg::RECIP_W-1:0] prod;
    prod = (rbb_pkg::TOT_W + rbb_pkg::RECIP_W)'(t) *
           (rbb_pkg::TOT_W + rbb_pkg::RECIP_W)'(rbb_pkg::RECIP_9);
    return prod[rbb_pkg::RECIP_SHIFT +: rbb_pkg::CH_W];
  endfunction

  logic         sum_valid_q;
  tot_t         sum_tot_q;
  rbb_pkg::rgb_t sum_center_q;
  logic         sum_interior_q;
  logic         sum_frame_end_q;
  tot_t         tot_d;

  logic               rsp_valid_q;
  rbb_pkg::out_item_t rsp_item_q;
  rbb_pkg::avg_rsp_t  rsp_d;

  always_comb begin
    tot_d.red   = rbb_pkg::TOT_W'(req_i.older.red) + rbb_pkg::TOT_W'(req_i.middle.red) +
                  rbb_pkg::TOT_W'(req_i.newest.red);
    tot_d.green = rbb_pkg::TOT_W'(req_i.older.green) + rbb_pkg::TOT_W'(req_i.middle.green) +
                  rbb_pkg::TOT_W'(req_i.newest.green);
    tot_d.blue  = rbb_pkg::TOT_W'(req_i.older.blue) + rbb_pkg::TOT_W'(req_i.middle.blue) +
                  rbb_pkg::TOT_W'(req_i.newest.blue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else begin
      sum_valid_q <= req_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_tot_q       <= tot_d;
    sum_center_q    <= req_i.center;
    sum_interior_q  <= req_i.interior;
    sum_frame_end_q <= req_i.frame_end;
  end

  // border positions keep the centre pixel
  always_comb begin
    rsp_d.valid          = sum_valid_q;
    rsp_d.item.frame_end = sum_frame_end_q;
    if (sum_interior_q) begin
      rsp_d.item.pix.red   = div9(sum_tot_q.red);
      rsp_d.item.pix.green = div9(sum_tot_q.green);
      rsp_d.item.pix.blue  = div9(sum_tot_q.blue);
    end else begin
      rsp_d.item.pix = sum_center_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_item_q <= rsp_d.item;
  end

  assign rsp_o = '{valid: rsp_valid_q, item: rsp_item_q};

endmodule

>>> src/rgb_box_blur_3x3_core.sv
// Channel  | Dir | Payload                                   | Handshake
// pix_i    | in  | red_in, green_in, blue_in, flush          | valid/ready
// pix_o    | out | red_out, green_out, blue_out, frame_end   | valid/ready
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i           | write on enable
//
// One item per clock while pix_i.ready holds; results pass read, window, averager, queue.
// Both line rows live in one 2048 x 48 RAM, read and written back once per item, with
// forwarding for the same column touched by two items in a row (drain end to next frame).
// Reset clears counters and control only; the RAM needs no clearing pass.
// pix_i.ready drops while eight results are in flight or waiting in the output queue.
`include "rgb_box_blur_3x3_core_macros.svh"

module rgb_box_blur_3x3_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  rbb_in_if.sink                           pix_i,
  rbb_out_if.source                        pix_o
);

  localparam int unsigned COL_W   = rbb_pkg::COL_W;
  localparam int unsigned ROW_W   = rbb_pkg::ROW_W;
  localparam int unsigned IMG_W_W = rbb_pkg::IMG_W_W;
  localparam int unsigned IMG_H_W = rbb_pkg::IMG_H_W;
  localparam int unsigned CNT_W   = rbb_pkg::OUT_CNT_W;
  localparam int unsigned PTR_W   = rbb_pkg::OUT_PTR_W;

  // frame geometry and position
  logic [IMG_W_W-1:0] width_q, width_d;
  logic [IMG_H_W-1:0] height_q, height_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;

  logic               accept;
  logic               pop;
  logic               col_nz;
  logic               emit_a;
  logic [ROW_W-1:0]   out_row_a;
  logic [COL_W-1:0]   out_col_a;
  rbb_pkg::rgb_t      pix_a;
  logic [IMG_W_W-1:0] col_inc;
  logic [IMG_W_W-1:0] cfg_w;
  logic [IMG_H_W-1:0] cfg_h;

  // read stage
  logic               s1_valid_q;
  logic               s1_emit_q;
  logic [COL_W-1:0]   s1_addr_q;
  logic [ROW_W-1:0]   s1_row_q;
  logic [COL_W-1:0]   s1_col_q;
  rbb_pkg::rgb_t      s1_pix_q;

  logic [rbb_pkg::LINE_W-1:0] ram_rdata;
  logic [rbb_pkg::LINE_W-1:0] line_rd;
  logic [rbb_pkg::LINE_W-1:0] line_wr;
  logic                       fwd_hit_d, fwd_hit_q;
  logic [rbb_pkg::LINE_W-1:0] fwd_data_q;

  rbb_pkg::rgb_t      above2;
  rbb_pkg::rgb_t      above1;
  rbb_pkg::csum_t     new_cs;
  logic               interior_b;
  logic               frame_end_b;
  logic [ROW_W:0]     row_p2;
  logic [IMG_W_W:0]   col_p2;

  // window: centre column pixel and the two older column sums
  rbb_pkg::rgb_t      w5_q;
  rbb_pkg::csum_t     csa_q;
  rbb_pkg::csum_t     csb_q;

  logic               s2_emit_q;
  logic               s2_interior_q;
  logic               s2_frame_end_q;
  rbb_pkg::rgb_t      s2_center_q;
  rbb_pkg::csum_t     s2_older_q;
  rbb_pkg::csum_t     s2_middle_q;
  rbb_pkg::csum_t     s2_newest_q;

  rbb_pkg::avg_req_t  avg_req;
  rbb_pkg::avg_rsp_t  avg_rsp;

  // output queue and credit count
  rbb_pkg::out_item_t fifo_q [rbb_pkg::OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [CNT_W-1:0]   fifo_cnt_q, fifo_cnt_d;
  logic [CNT_W-1:0]   resv_q, resv_d;

  // ---------------------------------------------------------------- accept stage
  assign pix_i.ready = resv_q < CNT_W'(rbb_pkg::OUT_DEPTH);
  assign accept      = pix_i.valid && pix_i.ready;
  assign pop         = pix_o.valid && pix_o.ready;

  always_comb begin
    col_nz    = col_q != '0;
    emit_a    = (col_nz && row_q != '0) || (!col_nz && row_q >= ROW_W'(2));
    out_row_a = col_nz ? row_q - ROW_W'(1) : row_q - ROW_W'(2);
    out_col_a = col_nz ? col_q - COL_W'(1) : COL_W'(width_q - IMG_W_W'(1));

    if (!pix_i.flush && row_q < ROW_W'(height_q)) begin
      pix_a.red   = pix_i.red_in;
      pix_a.green = pix_i.green_in;
      pix_a.blue  = pix_i.blue_in;
    end else begin
      pix_a = '0;
    end
  end

  always_comb begin
    cfg_w = cfg_data_i[IMG_W_W-1:0];
    if (cfg_w < IMG_W_W'(rbb_pkg::MIN_DIM)) begin
      cfg_w = IMG_W_W'(rbb_pkg::MIN_DIM);
    end else if (cfg_w > IMG_W_W'(rbb_pkg::MAX_WIDTH)) begin
      cfg_w = IMG_W_W'(rbb_pkg::MAX_WIDTH);
    end
    cfg_h = cfg_data_i[IMG_H_W-1:0];
    if (cfg_h < IMG_H_W'(rbb_pkg::MIN_DIM)) begin
      cfg_h = IMG_H_W'(rbb_pkg::MIN_DIM);
    end else if (cfg_h > IMG_H_W'(rbb_pkg::MAX_HEIGHT)) begin
      cfg_h = IMG_H_W'(rbb_pkg::MAX_HEIGHT);
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    col_inc  = IMG_W_W'(col_q) + IMG_W_W'(1);

    if (accept) begin
      if (row_q > ROW_W'(height_q)) begin
        // drain done: restart the frame
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= width_q) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = COL_W'(col_inc);
      end
    end

    if (cfg_we_i) begin
      case (rbb_pkg::cfg_reg_e'(cfg_idx_i))
        rbb_pkg::REG_IMAGE_WIDTH: begin
          width_d = cfg_w;
          col_d   = '0;
          row_d   = '0;
        end
        rbb_pkg::REG_IMAGE_HEIGHT: begin
          height_d = cfg_h;
          col_d    = '0;
          row_d    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= rbb_pkg::WIDTH_RESET;
      height_q   <= rbb_pkg::HEIGHT_RESET;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept;
      fwd_hit_q  <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_emit_q <= emit_a;
      s1_addr_q <= col_q;
      s1_row_q  <= out_row_a;
      s1_col_q  <= out_col_a;
      s1_pix_q  <= pix_a;
    end
  end

  // ---------------------------------------------------------------- line RAM
  rbb_ram #(
    .WIDTH (rbb_pkg::LINE_W),
    .DEPTH (rbb_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (line_wr),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // the RAM returns the old word when the same column is read while written back
  assign fwd_hit_d = accept && s1_valid_q && (col_q == s1_addr_q);

  always_ff @(posedge clk_i) begin
    fwd_data_q <= line_wr;
  end

  // ---------------------------------------------------------------- window stage
  always_comb begin
    line_rd = fwd_hit_q ? fwd_data_q : ram_rdata;
    above2  = line_rd[rbb_pkg::LINE_W-1:rbb_pkg::PIX_W];
    above1  = line_rd[rbb_pkg::PIX_W-1:0];
    line_wr = {above1, s1_pix_q};
    new_cs  = rbb_pkg::col_sum(above2, above1, s1_pix_q);

    row_p2      = (ROW_W+1)'(s1_row_q) + (ROW_W+1)'(2);
    col_p2      = (IMG_W_W+1)'(s1_col_q) + (IMG_W_W+1)'(2);
    interior_b  = (s1_row_q != '0) && (row_p2 <= (ROW_W+1)'(height_q)) &&
                  (s1_col_q != '0) && (col_p2 <= (IMG_W_W+1)'(width_q));
    frame_end_b = ((ROW_W+1)'(s1_row_q) + (ROW_W+1)'(1) == (ROW_W+1)'(height_q)) &&
                  ((IMG_W_W+1)'(s1_col_q) + (IMG_W_W+1)'(1) == (IMG_W_W+1)'(width_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_emit_q <= 1'b0;
    end else begin
      s2_emit_q <= s1_valid_q && s1_emit_q;
    end
  end

  // advance the window once per item, emitting or not
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      w5_q           <= above1;
      csa_q          <= csb_q;
      csb_q          <= new_cs;
      s2_center_q    <= w5_q;
      s2_older_q     <= csa_q;
      s2_middle_q    <= csb_q;
      s2_newest_q    <= new_cs;
      s2_interior_q  <= interior_b;
      s2_frame_end_q <= frame_end_b;
    end
  end

  always_comb begin
    avg_req.emit      = s2_emit_q;
    avg_req.interior  = s2_interior_q;
    avg_req.frame_end = s2_frame_end_q;
    avg_req.center    = s2_center_q;
    avg_req.older     = s2_older_q;
    avg_req.middle    = s2_middle_q;
    avg_req.newest    = s2_newest_q;
  end

  rbb_avg u_avg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (avg_req),
    .rsp_o  (avg_rsp)
  );

  // ---------------------------------------------------------------- output queue
  always_comb begin
    fifo_cnt_d = fifo_cnt_q + CNT_W'(avg_rsp.valid) - CNT_W'(pop);
    resv_d     = resv_q + CNT_W'(accept && emit_a) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      resv_q     <= '0;
    end else begin
      if (avg_rsp.valid) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      fifo_cnt_q <= fifo_cnt_d;
      resv_q     <= resv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (avg_rsp.valid) begin
      fifo_q[wr_ptr_q] <= avg_rsp.item;
    end
  end

  assign pix_o.valid     = fifo_cnt_q != '0;
  assign pix_o.red_out   = fifo_q[rd_ptr_q].pix.red;
  assign pix_o.green_out = fifo_q[rd_ptr_q].pix.green;
  assign pix_o.blue_out  = fifo_q[rd_ptr_q].pix.blue;
  assign pix_o.frame_end = fifo_q[rd_ptr_q].frame_end;

  // ---------------------------------------------------------------- assertions
  `RBB_ASSERT_ALWAYS(a_resv_bound, resv_q <= CNT_W'(rbb_pkg::OUT_DEPTH), "credit count exceeds queue depth")
  `RBB_ASSERT_ALWAYS(a_fifo_within_resv, fifo_cnt_q <= resv_q, "queued results exceed reserved credits")
  `RBB_ASSERT_IMPLIES(a_no_overflow, avg_rsp.valid, (fifo_cnt_q != CNT_W'(rbb_pkg::OUT_DEPTH)) || pop, "result written into a full queue")
  `RBB_ASSERT_ALWAYS(a_col_in_frame, IMG_W_W'(col_q) < width_q, "column position outside the row")
  `RBB_ASSERT_IMPLIES(a_fwd_at_row_start, fwd_hit_d, col_q == '0, "same column read twice in a row away from row start")

endmodule
